// ----- hw/rtl/ledc_pkg.sv -----
// shared types and constants of the addressable led chain driver
// no dependencies; imported by ledc_ram users, ledc_wave and the top level

package ledc_pkg;

    localparam int PIX_W          = 24;
    localparam int BIT_CNT_W      = 5;
    localparam int LED_COUNT_W    = 9;
    localparam int PULSE_W        = 8;
    localparam int GAP_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PIX_W - 1);

    // operation codes carried in s_tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TICKS = 3'd3;

    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST   = 9'd0;
    localparam logic [PULSE_W-1:0]     SHORT_TICKS_RST = 8'd6;
    localparam logic [PULSE_W-1:0]     LONG_TICKS_RST  = 8'd16;
    localparam logic [GAP_W-1:0]       RESET_TICKS_RST = 16'd1080;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } phase_t;

    typedef enum logic [1:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_EXEC
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic tick;
    } wave_cmd_t;

    typedef struct packed {
        phase_t phase;
        phase_t phase_next;
        logic   done;
    } wave_stat_t;

endpackage

// ----- hw/rtl/ledc_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies

module ledc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ledc_wave.sv -----
// serial waveform engine: bit shift register, bit and pixel counters, tick down counter
// depends on ledc_pkg

module ledc_wave
    import ledc_pkg::*;
#(
    parameter int MAX_LEDS = 256,
    localparam int CW = $clog2(MAX_LEDS + 1),
    localparam int EW = (CW > LED_COUNT_W) ? CW : LED_COUNT_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wave_cmd_t            cmd,
    input  logic [EW-1:0]        eff_count,
    input  logic [PULSE_W-1:0]   short_ticks,
    input  logic [PULSE_W-1:0]   long_ticks,
    input  logic [GAP_W-1:0]     reset_ticks,
    input  logic [PIX_W-1:0]     pix_word,
    output logic [EW-1:0]        pixel_count,
    output wave_stat_t           stat
);
    phase_t               phase_reg, phase_next;
    logic [EW-1:0]        pix_reg, pix_next, pix_inc;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [GAP_W-1:0]     tick_reg, tick_next;
    logic [PIX_W-1:0]     shift_reg, shift_next;
    logic                 done;
    logic [GAP_W-1:0]     short_len, long_len, gap_len;

    // a zero duration counts as one tick
    assign short_len = (short_ticks == '0) ? GAP_W'(1) : GAP_W'(short_ticks);
    assign long_len  = (long_ticks == '0) ? GAP_W'(1) : GAP_W'(long_ticks);
    assign gap_len   = (reset_ticks == '0) ? GAP_W'(1) : reset_ticks;
    assign pix_inc   = pix_reg + EW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pix_reg   <= '0;
            bit_reg   <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pix_reg   <= pix_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pix_next   = pix_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        done       = 1'b0;
        if (cmd.start && phase_reg == PH_IDLE) begin
            pix_next = '0;
            bit_next = '0;
            if (eff_count == '0) begin
                shift_next = '0;
                phase_next = PH_LATCH;
                tick_next  = gap_len;
            end else begin
                shift_next = pix_word;
                phase_next = PH_HIGH;
                tick_next  = pix_word[PIX_W-1] ? long_len : short_len;
            end
        end else if (cmd.tick && phase_reg != PH_IDLE) begin
            if (tick_reg > GAP_W'(1)) begin
                tick_next = tick_reg - GAP_W'(1);
            end else begin
                case (phase_reg)
                    PH_HIGH: begin
                        phase_next = PH_LOW;
                        tick_next  = shift_reg[PIX_W-1] ? short_len : long_len;
                    end
                    PH_LOW: begin
                        if (bit_reg < LAST_BIT) begin
                            // next bit of the same pixel moves to the top
                            bit_next   = bit_reg + BIT_CNT_W'(1);
                            shift_next = {shift_reg[PIX_W-2:0], 1'b0};
                            phase_next = PH_HIGH;
                            tick_next  = shift_reg[PIX_W-2] ? long_len : short_len;
                        end else begin
                            bit_next = '0;
                            pix_next = pix_inc;
                            if (pix_inc < eff_count) begin
                                shift_next = pix_word;
                                phase_next = PH_HIGH;
                                tick_next  = pix_word[PIX_W-1] ? long_len : short_len;
                            end else begin
                                phase_next = PH_LATCH;
                                tick_next  = gap_len;
                            end
                        end
                    end
                    PH_LATCH: begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        pix_next   = '0;
                        bit_next   = '0;
                        done       = 1'b1;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    assign pixel_count     = pix_reg;
    assign stat.phase      = phase_reg;
    assign stat.phase_next = phase_next;
    assign stat.done       = done;

endmodule

// ----- hw/rtl/addressable_led_chain_driver_core.sv -----
// Addressable LED chain driver core (single-wire serial LED protocol).
// Input channel s_*: one item per transfer, s_tuser is the operation
// (write pixel, start frame, one tick), s_tdata carries index and color.
// Result channel m_*: exactly one result per input item, in order:
// line level, busy and rejected in m_tdata, end of latch gap on m_tlast.
// Config channel cfg_*: always ready, register index and data, write
// only while no item is in flight.
// Each item is read from the frame store in the accept cycle (registered
// read port); the execute step then updates the waveform engine and loads
// the result register, whose output drives m_tvalid.
// The result register holds while m_tready is low, the next item is
// then accepted but waits in the execute step until the register frees.
// After reset the frame store is cleared one pixel per cycle, with
// s_tready low; config writes are taken during that time.
// Pixels go out green, red, blue, msb first, one bit per shift step.
// depends on ledc_pkg, ledc_ram, ledc_wave

module addressable_led_chain_driver_core
    import ledc_pkg::*;
#(
    parameter int MAX_LEDS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // blue, green, red, pixel_index
    input  logic [1:0]            s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // line_level, busy_res, rejected, zero fill
    output logic                  m_tlast,   // frame_done
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int CW = $clog2(MAX_LEDS + 1);
    localparam int EW = (CW > LED_COUNT_W) ? CW : LED_COUNT_W;
    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);
    localparam logic [EW-1:0] MAX_CNT   = EW'(MAX_LEDS);

    // configuration registers
    logic [LED_COUNT_W-1:0] led_count_reg;
    logic [PULSE_W-1:0]     short_ticks_reg, long_ticks_reg;
    logic [GAP_W-1:0]       reset_ticks_reg;
    logic [EW-1:0]          led_count_ext, eff_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg   <= LED_COUNT_RST;
            short_ticks_reg <= SHORT_TICKS_RST;
            long_ticks_reg  <= LONG_TICKS_RST;
            reset_ticks_reg <= RESET_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LED_COUNT:   led_count_reg   <= cfg_data[LED_COUNT_W-1:0];
                CFG_SHORT_TICKS: short_ticks_reg <= cfg_data[PULSE_W-1:0];
                CFG_LONG_TICKS:  long_ticks_reg  <= cfg_data[PULSE_W-1:0];
                CFG_RESET_TICKS: reset_ticks_reg <= cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready     = 1'b1;
    assign led_count_ext = EW'(led_count_reg);
    assign eff_count     = (led_count_ext > MAX_CNT) ? MAX_CNT : led_count_ext;

    // sequencer
    seq_state_t       sq_state_reg, sq_state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [1:0]       op_reg;
    logic [7:0]       idx_reg;
    logic [PIX_W-1:0] color_reg;
    logic             accept, out_free, exec_fire;

    logic             m_tvalid_reg;
    logic             line_reg, busy_reg, rej_reg, done_reg;
    logic             rej_next, busy_now, bad_index;

    wave_cmd_t        wcmd;
    wave_stat_t       wstat;
    logic [EW-1:0]    pixel_count, pix_inc;
    logic [PIX_W-1:0] pix_word;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [PIX_W-1:0] ram_wdata;

    assign s_tready  = (sq_state_reg == SQ_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_fire = (sq_state_reg == SQ_EXEC) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_state_reg <= SQ_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            sq_state_reg <= sq_state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb begin
        sq_state_next = sq_state_reg;
        clr_addr_next = clr_addr_reg;
        case (sq_state_reg)
            SQ_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    sq_state_next = SQ_IDLE;
                end
            end
            SQ_IDLE: begin
                if (accept) begin
                    sq_state_next = SQ_EXEC;
                end
            end
            SQ_EXEC: begin
                if (out_free) begin
                    sq_state_next = SQ_IDLE;
                end
            end
            default: begin
                sq_state_next = SQ_IDLE;
            end
        endcase
    end

    // captured item, payload only
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_tuser;
            idx_reg   <= s_tdata[7:0];
            color_reg <= {s_tdata[23:16], s_tdata[15:8], s_tdata[31:24]};
        end
    end

    assign busy_now  = (wstat.phase != PH_IDLE);
    assign bad_index = (EW'(idx_reg) >= eff_count);

    always_comb begin
        rej_next = 1'b0;
        case (op_reg)
            OP_WRITE: rej_next = busy_now || bad_index;
            OP_START: rej_next = busy_now;
            default:  rej_next = 1'b0;
        endcase
    end

    assign wcmd.start = exec_fire && (op_reg == OP_START);
    assign wcmd.tick  = exec_fire && (op_reg == OP_TICK);

    // frame store: clear sweep, pixel writes, prefetch read at accept
    assign pix_inc   = pixel_count + EW'(1);
    assign ram_re    = accept;
    assign ram_raddr = (s_tuser == OP_START) ? '0 : pix_inc[AW-1:0];
    assign ram_we    = (sq_state_reg == SQ_CLEAR) ||
                       (exec_fire && (op_reg == OP_WRITE) && !rej_next);
    assign ram_waddr = (sq_state_reg == SQ_CLEAR) ? clr_addr_reg : AW'(idx_reg);
    assign ram_wdata = (sq_state_reg == SQ_CLEAR) ? '0 : color_reg;

    ledc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (pix_word)
    );

    ledc_wave #(
        .MAX_LEDS (MAX_LEDS)
    ) u_wave (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (wcmd),
        .eff_count   (eff_count),
        .short_ticks (short_ticks_reg),
        .long_ticks  (long_ticks_reg),
        .reset_ticks (reset_ticks_reg),
        .pix_word    (pix_word),
        .pixel_count (pixel_count),
        .stat        (wstat)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            line_reg <= (wstat.phase_next == PH_HIGH);
            busy_reg <= (wstat.phase_next != PH_IDLE);
            rej_reg  <= rej_next;
            done_reg <= wstat.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, rej_reg, busy_reg, line_reg};
    assign m_tlast  = done_reg;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (!m_tdata[1] && !m_tdata[0]))
        else $error("frame end reported while line still busy");

    a_high_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
        else $error("line high outside a frame");

    a_reject_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && rej_next) |-> (op_reg == OP_WRITE || op_reg == OP_START))
        else $error("rejection on a tick or unused operation");

    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (wcmd.start && wstat.phase == PH_IDLE) |=> (wstat.phase != PH_IDLE))
        else $error("start from idle did not begin a frame");
`endif

endmodule
